// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: command codes,
// status codes, cell chain modes and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DATA_W = 32;
   localparam logic [DATA_W-1:0] VALUE_FAIL = '1;

   typedef enum logic [3:0] {
      OP_INS_HEAD  = 4'd0,
      OP_INS_TAIL  = 4'd1,
      OP_INS_POS   = 4'd2,
      OP_DEL_HEAD  = 4'd3,
      OP_DEL_TAIL  = 4'd4,
      OP_DEL_VALUE = 4'd5,
      OP_SEARCH    = 4'd6,
      OP_GET       = 4'd7,
      OP_REVERSE   = 4'd8,
      OP_CLEAR     = 4'd9
   } opcode_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_BADPOS   = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_CMP,
      MODE_INS,
      MODE_DEL,
      MODE_MIRROR,
      MODE_SHIFT
   } chain_mode_type;

   typedef struct packed {
      chain_mode_type    mode;
      logic [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

// ===== rtl/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of
// cells; inserts open a gap and removals close one.
// Flow: idle, then execute, which registers the response; search and
// delete-by-value pass through the compare and find states before execute.
// No new command is taken while busy; reverse of a list that is not full then realigns one slot per cycle.
// Reset: list empty, engine idle. The receiver cannot stall rsp_valid.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [3:0]         rsp_position_out,
   output logic [4:0]         rsp_count_out,
   output logic               rsp_is_empty
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CW > 5) ? CW : 5;
   localparam int DW = ple_pkg::DATA_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_FIND,
      S_EXEC,
      S_SHIFT
   } state_type;

   state_type         state_ff;
   logic [3:0]        op_ff;
   logic [DW-1:0]     value_ff;
   logic [4:0]        pos_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     at_ff;
   logic              found_ff;
   logic [CW-1:0]     rem_ff;

   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [DW-1:0]     rsp_value_ff;
   logic [3:0]        rsp_position_ff;
   logic [CW-1:0]     rsp_count_ff;

   ple_pkg::cell_ctl_type ctl;
   logic [DW-1:0]     cell_data [CAPACITY];
   logic [DW-1:0]     data_ext  [CAPACITY+2];
   logic [CAPACITY:0] seen;
   logic [CAPACITY-1:0] first;

   logic [CW-1:0]     find_idx;
   logic [CW-1:0]     rd_idx;
   logic [DW-1:0]     rd_data;

   ple_pkg::chain_mode_type exe_mode;
   logic [CW-1:0]     exe_at;
   logic [CW-1:0]     exe_count;
   logic [2:0]        exe_status;
   logic [DW-1:0]     exe_vout;
   logic [AW-1:0]     exe_pout;
   logic              exe_shift;
   logic [CW-1:0]     exe_rem;

   logic [AW-1:0]     count_w;
   logic [AW-1:0]     pos_w;
   logic [AW-1:0]     ins_at;
   logic [AW-1:0]     cnt_ext;

   assign count_w = AW'(count_ff);
   assign pos_w   = AW'(pos_ff);

   // ---------------- cell chain ----------------
   always_comb begin
      ctl.value = value_ff;
      case (state_ff)
         S_CMP:   ctl.mode = ple_pkg::MODE_CMP;
         S_EXEC:  ctl.mode = exe_mode;
         S_SHIFT: ctl.mode = ple_pkg::MODE_SHIFT;
         default: ctl.mode = ple_pkg::MODE_IDLE;
      endcase
   end

   assign data_ext[0]          = '0;
   assign data_ext[CAPACITY+1] = '0;
   assign seen[0]              = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign data_ext[i+1] = cell_data[i];

      ple_cell #(
         .IDX_W (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .index       (CW'(i)),
         .at          (exe_at),
         .count       (count_ff),
         .prev_data   (data_ext[i]),
         .next_data   (data_ext[i+2]),
         .mirror_data (data_ext[CAPACITY-i]),
         .seen_in     (seen[i]),
         .data        (cell_data[i]),
         .seen_out    (seen[i+1]),
         .first       (first[i])
      );
   end

   always_comb begin
      find_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first[i]) begin
            find_idx = find_idx | CW'(i);
         end
      end
   end

   // ---------------- entry read ----------------
   always_comb begin
      case (op_ff)
         ple_pkg::OP_DEL_TAIL:  rd_idx = count_ff - CW'(1);
         ple_pkg::OP_DEL_VALUE: rd_idx = at_ff;
         ple_pkg::OP_GET:       rd_idx = pos_w[CW-1:0];
         default:               rd_idx = '0;
      endcase
   end

   always_comb begin
      rd_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_idx == CW'(i)) begin
            rd_data = rd_data | cell_data[i];
         end
      end
   end

   // ---------------- command decode ----------------
   always_comb begin
      case (op_ff)
         ple_pkg::OP_INS_HEAD: ins_at = '0;
         ple_pkg::OP_INS_TAIL: ins_at = count_w;
         default:              ins_at = pos_w;
      endcase
   end

   always_comb begin
      exe_mode   = ple_pkg::MODE_IDLE;
      exe_at     = '0;
      exe_count  = count_ff;
      exe_status = ple_pkg::STAT_OK;
      exe_vout   = '0;
      exe_pout   = '0;
      exe_shift  = 1'b0;
      exe_rem    = CW'(CAPACITY) - count_ff;
      case (op_ff)
         ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_TAIL, ple_pkg::OP_INS_POS: begin
            if (ins_at > count_w) begin
               exe_status = ple_pkg::STAT_BADPOS;
            end else if (count_ff == CW'(CAPACITY)) begin
               exe_status = ple_pkg::STAT_FULL;
            end else begin
               exe_mode  = ple_pkg::MODE_INS;
               exe_at    = ins_at[CW-1:0];
               exe_count = count_ff + CW'(1);
               exe_vout  = value_ff;
               exe_pout  = ins_at;
            end
         end
         ple_pkg::OP_DEL_HEAD, ple_pkg::OP_DEL_TAIL: begin
            if (count_ff == '0) begin
               exe_status = ple_pkg::STAT_EMPTY;
            end else begin
               exe_mode  = ple_pkg::MODE_DEL;
               exe_at    = rd_idx;
               exe_count = count_ff - CW'(1);
               exe_vout  = rd_data;
               exe_pout  = AW'(rd_idx);
            end
         end
         ple_pkg::OP_DEL_VALUE: begin
            if (count_ff == '0) begin
               exe_status = ple_pkg::STAT_EMPTY;
            end else if (!found_ff) begin
               exe_status = ple_pkg::STAT_NOTFOUND;
            end else begin
               exe_mode  = ple_pkg::MODE_DEL;
               exe_at    = at_ff;
               exe_count = count_ff - CW'(1);
               exe_vout  = rd_data;
               exe_pout  = AW'(at_ff);
            end
         end
         ple_pkg::OP_SEARCH: begin
            if (!found_ff) begin
               exe_status = ple_pkg::STAT_NOTFOUND;
            end else begin
               exe_vout = value_ff;
               exe_pout = AW'(at_ff);
            end
         end
         ple_pkg::OP_GET: begin
            if (pos_w >= count_w) begin
               exe_status = ple_pkg::STAT_BADPOS;
               exe_vout   = ple_pkg::VALUE_FAIL;
            end else begin
               exe_vout = rd_data;
               exe_pout = pos_w;
            end
         end
         ple_pkg::OP_REVERSE: begin
            exe_mode  = ple_pkg::MODE_MIRROR;
            exe_shift = (exe_rem != '0);
         end
         ple_pkg::OP_CLEAR: begin
            exe_count = '0;
         end
         default: begin
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_opcode;
                  value_ff <= req_value;
                  pos_ff   <= req_position;
                  if (req_opcode == ple_pkg::OP_DEL_VALUE ||
                      req_opcode == ple_pkg::OP_SEARCH) begin
                     state_ff <= S_CMP;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_CMP: begin
               state_ff <= S_FIND;
            end
            S_FIND: begin
               at_ff    <= find_idx;
               found_ff <= |first;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               count_ff <= exe_count;
               if (exe_shift) begin
                  rem_ff   <= exe_rem;
                  state_ff <= S_SHIFT;
               end else begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= exe_status;
                  rsp_value_ff    <= exe_vout;
                  rsp_position_ff <= exe_pout[3:0];
                  rsp_count_ff    <= exe_count;
                  state_ff        <= S_IDLE;
               end
            end
            S_SHIFT: begin
               rem_ff <= rem_ff - CW'(1);
               if (rem_ff == CW'(1)) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= ple_pkg::STAT_OK;
                  rsp_value_ff    <= '0;
                  rsp_position_ff <= '0;
                  rsp_count_ff    <= count_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign cnt_ext = AW'(rsp_count_ff);

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_position_out = rsp_position_ff;
   assign rsp_count_out    = cnt_ext[4:0];
   assign rsp_is_empty     = (rsp_count_ff == '0);

endmodule

// ===== rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, takes a neighbor's entry when the list opens or closes a gap
// and the mirrored entry on reverse, compares against the key and forms the first-match chain.
// ----------------------------------------------------------------------------
module ple_cell #(
   parameter int IDX_W = 5
) (
   input  logic                      clock,
   input  ple_pkg::cell_ctl_type     ctl,
   input  logic [IDX_W-1:0]          index,
   input  logic [IDX_W-1:0]          at,
   input  logic [IDX_W-1:0]          count,
   input  logic [ple_pkg::DATA_W-1:0] prev_data,
   input  logic [ple_pkg::DATA_W-1:0] next_data,
   input  logic [ple_pkg::DATA_W-1:0] mirror_data,
   input  logic                      seen_in,
   output logic [ple_pkg::DATA_W-1:0] data,
   output logic                      seen_out,
   output logic                      first
);

   logic [ple_pkg::DATA_W-1:0] data_ff, data_in;
   logic                       match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      case (ctl.mode)
         ple_pkg::MODE_CMP: begin
            match_in = (data_ff == ctl.value) && (index < count);
         end
         ple_pkg::MODE_INS: begin
            if (index > at) begin
               data_in = prev_data;
            end else if (index == at) begin
               data_in = ctl.value;
            end
         end
         ple_pkg::MODE_DEL: begin
            if (index >= at) begin
               data_in = next_data;
            end
         end
         ple_pkg::MODE_MIRROR: begin
            data_in = mirror_data;
         end
         ple_pkg::MODE_SHIFT: begin
            data_in = next_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data     = data_ff;
   assign first    = match_ff & ~seen_in;
   assign seen_out = match_ff | seen_in;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_engine_top. A queue-based list
// mirror predicts every response, and each strobed response is checked
// field by field against the oldest pending prediction. Directed cases on
// the empty list and the field extremes come first. Fill/drain passes and
// random command mixes then follow under three sender idle profiles.
// ----------------------------------------------------------------------------
module tb;

   localparam int CAPACITY = 16;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
   localparam int DRAIN_CYCLES = CAPACITY + 8;

   typedef struct packed {
      ple_pkg::status_type status;
      logic signed [31:0]  value;
      logic [3:0]          position;
      logic [4:0]          count;
      logic                empty;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [3:0]         req_opcode = ple_pkg::OP_INS_HEAD;
   logic signed [31:0] req_value = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_value_out;
   logic [3:0]         rsp_position_out;
   logic [4:0]         rsp_count_out;
   logic               rsp_is_empty;

   logic signed [31:0] list_mirror[$];
   list_result_type    list_results_due[$];
   int                 idle_pct = 0;
   int                 fail_count = 0;

   positional_list_engine_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out),
      .rsp_position_out(rsp_position_out),
      .rsp_count_out(rsp_count_out),
      .rsp_is_empty(rsp_is_empty)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb: errors");
      $finish;
   end

   function automatic int find_first(input logic signed [31:0] val);
      for (int i = 0; i < list_mirror.size(); i++) begin
         if (list_mirror[i] == val) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one command to the mirror and returns the response it implies.
   function automatic list_result_type run_list_command(input logic [3:0] op,
                                                        input logic signed [31:0] val,
                                                        input logic [4:0] pos);
      list_result_type res;
      int at;
      logic signed [31:0] tmp;
      int n;

      res = '0;
      res.status = ple_pkg::STAT_OK;
      n = list_mirror.size();
      case (op)
         ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_TAIL, ple_pkg::OP_INS_POS: begin
            at = (op == ple_pkg::OP_INS_HEAD) ? 0 :
                 (op == ple_pkg::OP_INS_TAIL) ? n : int'(pos);
            if (at > n) begin
               res.status = ple_pkg::STAT_BADPOS;
            end else if (n >= CAPACITY) begin
               res.status = ple_pkg::STAT_FULL;
            end else begin
               list_mirror.insert(at, val);
               res.value = val;
               res.position = at[3:0];
            end
         end
         ple_pkg::OP_DEL_HEAD, ple_pkg::OP_DEL_TAIL: begin
            if (n == 0) begin
               res.status = ple_pkg::STAT_EMPTY;
            end else begin
               at = (op == ple_pkg::OP_DEL_HEAD) ? 0 : n - 1;
               res.value = list_mirror[at];
               res.position = at[3:0];
               list_mirror.delete(at);
            end
         end
         ple_pkg::OP_DEL_VALUE: begin
            at = find_first(val);
            if (n == 0) begin
               res.status = ple_pkg::STAT_EMPTY;
            end else if (at < 0) begin
               res.status = ple_pkg::STAT_NOTFOUND;
            end else begin
               res.value = list_mirror[at];
               res.position = at[3:0];
               list_mirror.delete(at);
            end
         end
         ple_pkg::OP_SEARCH: begin
            at = find_first(val);
            if (at < 0) begin
               res.status = ple_pkg::STAT_NOTFOUND;
            end else begin
               res.value = val;
               res.position = at[3:0];
            end
         end
         ple_pkg::OP_GET: begin
            if (int'(pos) >= n) begin
               res.status = ple_pkg::STAT_BADPOS;
               res.value = ple_pkg::VALUE_FAIL;
            end else begin
               res.value = list_mirror[pos];
               res.position = pos[3:0];
            end
         end
         ple_pkg::OP_REVERSE: begin
            for (int i = 0; i < n / 2; i++) begin
               tmp = list_mirror[i];
               list_mirror[i] = list_mirror[n - 1 - i];
               list_mirror[n - 1 - i] = tmp;
            end
         end
         ple_pkg::OP_CLEAR: begin
            list_mirror.delete();
         end
         default: begin
         end
      endcase
      n = list_mirror.size();
      res.count = n[4:0];
      res.empty = (n == 0);
      return res;
   endfunction

   // One transaction: optional idle gap, then raise start and wait while busy.
   task automatic issue_command(input logic [3:0] op, input logic signed [31:0] val,
                                input logic [4:0] pos);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_value <= val;
      req_position <= pos;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      list_results_due.push_back(run_list_command(op, val, pos));
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (list_results_due.size() == 0) begin
            $error("unexpected response: status %0d value %0d", rsp_status, rsp_value_out);
            fail_count++;
         end else begin
            want = list_results_due.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_value_out !== want.value) begin
               $error("value_out: expected %0d, got %0d", want.value, rsp_value_out);
               fail_count++;
            end
            if (rsp_position_out !== want.position) begin
               $error("position_out: expected %0d, got %0d", want.position,
                      rsp_position_out);
               fail_count++;
            end
            if (rsp_count_out !== want.count) begin
               $error("count_out: expected %0d, got %0d", want.count, rsp_count_out);
               fail_count++;
            end
            if (rsp_is_empty !== want.empty) begin
               $error("is_empty: expected %0d, got %0d", want.empty, rsp_is_empty);
               fail_count++;
            end
         end
      end
   end

   // Half the time reuse a stored value so searches and removals hit.
   function automatic logic signed [31:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (list_mirror.size() != 0 && roll < 50) begin
         return list_mirror[$urandom_range(list_mirror.size() - 1)];
      end else if (roll < 55) begin
         return INT_MIN;
      end else if (roll < 60) begin
         return INT_MAX;
      end else if (roll < 64) begin
         return 32'sd0;
      end
      return $urandom;
   endfunction

   function automatic logic [4:0] pick_position();
      if ($urandom_range(99) < 80) begin
         return 5'($urandom_range(list_mirror.size()));
      end
      return 5'($urandom_range(31));
   endfunction

   task automatic test_empty_list();
      issue_command(ple_pkg::OP_DEL_HEAD, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_DEL_TAIL, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_DEL_VALUE, INT_MIN, 5'd0);
      issue_command(ple_pkg::OP_SEARCH, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_GET, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_INS_POS, 32'sd7, 5'd1);
      issue_command(ple_pkg::OP_REVERSE, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_CLEAR, 32'sd0, 5'd0);
   endtask

   task automatic test_field_extremes();
      issue_command(ple_pkg::OP_INS_HEAD, INT_MIN, 5'd0);
      issue_command(ple_pkg::OP_INS_TAIL, INT_MAX, 5'd31);
      issue_command(ple_pkg::OP_INS_POS, 32'hffff_ffff, 5'd1);
      issue_command(ple_pkg::OP_INS_POS, 32'sd0, 5'd3);
      issue_command(ple_pkg::OP_INS_POS, 32'sh5555_5555, 5'd31);
      issue_command(ple_pkg::OP_INS_TAIL, 32'hffff_ffff, 5'd0);
      issue_command(ple_pkg::OP_SEARCH, 32'hffff_ffff, 5'd0);
      issue_command(ple_pkg::OP_SEARCH, 32'sh1234_5678, 5'd0);
      issue_command(ple_pkg::OP_GET, 32'sd0, 5'd4);
      issue_command(ple_pkg::OP_GET, 32'sd0, 5'd5);
      issue_command(ple_pkg::OP_GET, 32'sd0, 5'd16);
      issue_command(ple_pkg::OP_REVERSE, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_GET, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_DEL_VALUE, 32'hffff_ffff, 5'd0);
      issue_command(ple_pkg::OP_DEL_VALUE, 32'sd7, 5'd0);
      issue_command(4'(int'(ple_pkg::OP_CLEAR) + 1), INT_MAX, 5'd31);
      issue_command(4'hf, INT_MIN, 5'd16);
      issue_command(ple_pkg::OP_DEL_HEAD, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_DEL_TAIL, 32'sd0, 5'd0);
   endtask

   task automatic test_fill_and_drain();
      logic [3:0] op;
      while (list_mirror.size() < CAPACITY) begin
         op = 4'($urandom_range(int'(ple_pkg::OP_INS_POS), int'(ple_pkg::OP_INS_HEAD)));
         issue_command(op, pick_value(), 5'($urandom_range(list_mirror.size())));
      end
      issue_command(ple_pkg::OP_INS_HEAD, pick_value(), 5'd0);
      issue_command(ple_pkg::OP_INS_POS, pick_value(), 5'(CAPACITY));
      issue_command(ple_pkg::OP_INS_POS, pick_value(), 5'(CAPACITY + 1));
      issue_command(ple_pkg::OP_REVERSE, 32'sd0, 5'd0);
      issue_command(ple_pkg::OP_GET, 32'sd0, 5'(CAPACITY - 1));
      while (list_mirror.size() > 0) begin
         op = 4'($urandom_range(int'(ple_pkg::OP_DEL_VALUE), int'(ple_pkg::OP_DEL_HEAD)));
         issue_command(op, pick_value(), 5'd0);
      end
      issue_command(ple_pkg::OP_DEL_VALUE, pick_value(), 5'd0);
   endtask

   task automatic test_random_mix(input int n_items);
      int roll;
      logic [3:0] op;
      repeat (n_items) begin
         roll = $urandom_range(99);
         if (roll < 14) op = ple_pkg::OP_INS_HEAD;
         else if (roll < 28) op = ple_pkg::OP_INS_TAIL;
         else if (roll < 42) op = ple_pkg::OP_INS_POS;
         else if (roll < 50) op = ple_pkg::OP_DEL_HEAD;
         else if (roll < 58) op = ple_pkg::OP_DEL_TAIL;
         else if (roll < 68) op = ple_pkg::OP_DEL_VALUE;
         else if (roll < 78) op = ple_pkg::OP_SEARCH;
         else if (roll < 90) op = ple_pkg::OP_GET;
         else if (roll < 94) op = ple_pkg::OP_REVERSE;
         else if (roll < 96) op = ple_pkg::OP_CLEAR;
         else op = 4'($urandom_range(15, int'(ple_pkg::OP_CLEAR) + 1));
         issue_command(op, pick_value(), pick_position());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 13;
      test_empty_list();
      test_field_extremes();
      test_fill_and_drain();
      test_random_mix(440);

      idle_pct = 71;
      test_fill_and_drain();
      test_random_mix(440);

      idle_pct = 0;
      test_fill_and_drain();
      test_random_mix(440);

      start <= 1'b0;
      while (list_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
